// ----- rtl/gamepad_edge_and_autorepeat_assert.svh -----
// ----------------------------------------------------------------------------
// gamepad edge and auto-repeat assertion macros
// shared concurrent assertion forms for the gamepad block
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_EDGE_AND_AUTOREPEAT_ASSERT_SVH
`define GAMEPAD_EDGE_AND_AUTOREPEAT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GEA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gamepad block: same-cycle check failed");

// next-cycle implication, checked outside reset
`define GEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gamepad block: next-cycle check failed");

`endif

// ----- rtl/gea_pkg.sv -----
// ----------------------------------------------------------------------------
// gamepad edge and auto-repeat package
// shared constants, types and line-mapping functions
// ----------------------------------------------------------------------------
package gea_pkg;

    localparam int SRC_LINES  = 20;
    localparam int LINE_COUNT = 22;
    localparam int BTN_COUNT  = 12;
    localparam int CNT_W      = 4;
    localparam int AXIS_W     = 8;
    localparam int THR_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam int BTN_CIRCLE = 7;
    localparam int BTN_CROSS  = 8;

    localparam logic [AXIS_W-1:0] AXIS_CENTRE = 8'd128;
    localparam logic [THR_W-1:0]  THR_RST     = 7'd64;
    localparam logic [CNT_W-1:0]  DELAY_RST   = 4'd10;
    localparam logic [CNT_W-1:0]  RELOAD_RST  = 4'd6;
    localparam logic [CNT_W-1:0]  CNT_MAX     = 4'd15;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTER_IS_CIRCLE = 2'd0,
        CFG_AXIS_THRESHOLD  = 2'd1,
        CFG_REPEAT_DELAY    = 2'd2,
        CFG_REPEAT_RELOAD   = 2'd3
    } t_cfg_idx;

    // repeat timing handed to the counter bank
    typedef struct packed {
        logic [CNT_W-1:0] delay;
        logic [CNT_W-1:0] reload;
    } t_rpt_cfg;

    // two direction bits of one axis: bit 0 low side, bit 1 high side
    function automatic logic [1:0] axis_dirs(input logic [AXIS_W-1:0] a,
                                             input logic [THR_W-1:0]  t);
        logic [AXIS_W-1:0] lim_lo;
        logic [AXIS_W-1:0] lim_hi;
        lim_lo = AXIS_CENTRE - {1'b0, t};
        lim_hi = AXIS_CENTRE + {1'b0, t};
        if (a < lim_lo) begin
            axis_dirs = 2'b01;
        end else if (a > lim_hi) begin
            axis_dirs = 2'b10;
        end else begin
            axis_dirs = 2'b00;
        end
    endfunction

    // spread the source lines into the output layout with enter and cancel
    function automatic logic [LINE_COUNT-1:0] spread(input logic [SRC_LINES-1:0] src,
                                                     input logic enter_is_circle);
        logic enter;
        logic cancel;
        enter  = enter_is_circle ? src[BTN_CIRCLE] : src[BTN_CROSS];
        cancel = enter_is_circle ? src[BTN_CROSS] : src[BTN_CIRCLE];
        spread = {src[SRC_LINES-1:BTN_COUNT], cancel, enter, src[BTN_COUNT-1:0]};
    endfunction

endpackage

// ----- rtl/gea_repeat.sv -----
// ----------------------------------------------------------------------------
// gea repeat counter bank
// per-line hold counters producing slow and fast auto-repeat pulses
// ----------------------------------------------------------------------------
module gea_repeat
    import gea_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [SRC_LINES-1:0] i_cur,
    input  t_rpt_cfg             i_cfg,
    output logic [SRC_LINES-1:0] o_slow,
    output logic [SRC_LINES-1:0] o_fast
);

    logic [CNT_W-1:0] r_slow_cnt [SRC_LINES];
    logic [CNT_W-1:0] r_fast_cnt [SRC_LINES];
    logic [CNT_W-1:0] n_slow_cnt [SRC_LINES];
    logic [CNT_W-1:0] n_fast_cnt [SRC_LINES];

    for (genvar g = 0; g < SRC_LINES; g++) begin : g_line
        logic             slow_hit;
        logic             fast_hit;
        logic [CNT_W-1:0] slow_base;
        logic [CNT_W-1:0] fast_base;

        // pulse when the count reaches the delay, then reload and count on
        always_comb begin
            slow_hit  = r_slow_cnt[g] >= i_cfg.delay;
            fast_hit  = r_fast_cnt[g] >= i_cfg.delay;
            slow_base = slow_hit ? i_cfg.reload : r_slow_cnt[g];
            fast_base = fast_hit ? i_cfg.delay : r_fast_cnt[g];
            if (i_cur[g]) begin
                n_slow_cnt[g] = (slow_base == CNT_MAX) ? CNT_MAX : slow_base + 1'b1;
                n_fast_cnt[g] = (fast_base == CNT_MAX) ? CNT_MAX : fast_base + 1'b1;
            end else begin
                n_slow_cnt[g] = '0;
                n_fast_cnt[g] = '0;
            end
        end

        assign o_slow[g] = i_cur[g] & slow_hit;
        assign o_fast[g] = i_cur[g] & fast_hit;

        // counters advance once per accepted beat
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_slow_cnt[g] <= '0;
                r_fast_cnt[g] <= '0;
            end else if (i_step) begin
                r_slow_cnt[g] <= n_slow_cnt[g];
                r_fast_cnt[g] <= n_fast_cnt[g];
            end
        end
    end

endmodule

// ----- rtl/gamepad_edge_and_autorepeat.sv -----
// ----------------------------------------------------------------------------
// gamepad edge and auto-repeat
// per-frame button and stick edge detection with two auto-repeat pulse forms
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready     | buttons and four axes
//  out     | output    | o_out_valid / i_out_ready   | five 22-bit line masks
//  cfg     | input     | i_cfg_we                    | i_cfg_idx, i_cfg_wdata
//
// one beat per cycle while the output is not stalled: a sample accepted at an
// edge gives its result beat at the output register after that edge.
// the input is ready whenever the output register is empty or being taken,
// so a stalled output holds exactly one result and back-pressures the input.
// synchronous active-low reset clears history and counters and restores the configuration defaults.
// ----------------------------------------------------------------------------
module gamepad_edge_and_autorepeat
    import gea_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [BTN_COUNT-1:0]  i_button_bits,
    input  logic [AXIS_W-1:0]     i_left_x,
    input  logic [AXIS_W-1:0]     i_left_y,
    input  logic [AXIS_W-1:0]     i_right_x,
    input  logic [AXIS_W-1:0]     i_right_y,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [LINE_COUNT-1:0] o_level_mask,
    output logic [LINE_COUNT-1:0] o_press_mask,
    output logic [LINE_COUNT-1:0] o_release_mask,
    output logic [LINE_COUNT-1:0] o_slow_repeat_mask,
    output logic [LINE_COUNT-1:0] o_fast_repeat_mask,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

`include "gamepad_edge_and_autorepeat_assert.svh"

    logic                  r_enter_is_circle;
    logic [THR_W-1:0]      r_axis_threshold;
    t_rpt_cfg              r_rpt_cfg;
    logic [SRC_LINES-1:0]  r_prev;
    logic                  r_out_valid;
    logic [LINE_COUNT-1:0] r_level;
    logic [LINE_COUNT-1:0] r_press;
    logic [LINE_COUNT-1:0] r_release;
    logic [LINE_COUNT-1:0] r_slow;
    logic [LINE_COUNT-1:0] r_fast;

    logic                  in_beat;
    logic [SRC_LINES-1:0]  n_cur;
    logic [SRC_LINES-1:0]  press;
    logic [SRC_LINES-1:0]  release_src;
    logic [SRC_LINES-1:0]  rpt_slow;
    logic [SRC_LINES-1:0]  rpt_fast;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter_is_circle <= 1'b0;
            r_axis_threshold  <= THR_RST;
            r_rpt_cfg.delay   <= DELAY_RST;
            r_rpt_cfg.reload  <= RELOAD_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ENTER_IS_CIRCLE: r_enter_is_circle <= i_cfg_wdata[0];
                CFG_AXIS_THRESHOLD:  r_axis_threshold  <= i_cfg_wdata[THR_W-1:0];
                CFG_REPEAT_DELAY:    r_rpt_cfg.delay   <= i_cfg_wdata[CNT_W-1:0];
                CFG_REPEAT_RELOAD:   r_rpt_cfg.reload  <= i_cfg_wdata[CNT_W-1:0];
                default:             r_enter_is_circle <= r_enter_is_circle;
            endcase
        end
    end

    // handshake: take a beat whenever the output slot frees up
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_beat    = i_in_valid && o_in_ready;

    // source lines: buttons then stick directions
    always_comb begin
        n_cur = {axis_dirs(i_right_x, r_axis_threshold),
                 axis_dirs(i_right_y, r_axis_threshold),
                 axis_dirs(i_left_x, r_axis_threshold),
                 axis_dirs(i_left_y, r_axis_threshold),
                 i_button_bits};
        press       = n_cur & ~r_prev;
        release_src = ~n_cur & r_prev;
    end

    // hold counters and repeat pulses
    gea_repeat u_repeat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_beat),
        .i_cur   (n_cur),
        .i_cfg   (r_rpt_cfg),
        .o_slow  (rpt_slow),
        .o_fast  (rpt_fast)
    );

    // level history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (in_beat) begin
            r_prev <= n_cur;
        end
    end

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_level   <= spread(n_cur, r_enter_is_circle);
            r_press   <= spread(press, r_enter_is_circle);
            r_release <= spread(release_src, r_enter_is_circle);
            r_slow    <= spread(rpt_slow | press, r_enter_is_circle);
            r_fast    <= spread(rpt_fast | press, r_enter_is_circle);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_level_mask       = r_level;
    assign o_press_mask       = r_press;
    assign o_release_mask     = r_release;
    assign o_slow_repeat_mask = r_slow;
    assign o_fast_repeat_mask = r_fast;

    // a line never presses and releases in the same frame
    `GEA_ASSERT_IMPL(a_press_release_disjoint, i_clk, i_rst_n, o_out_valid, (o_press_mask & o_release_mask) == '0)
    // press and repeat pulses only on held lines
    `GEA_ASSERT_IMPL(a_pulses_on_held, i_clk, i_rst_n, o_out_valid, ((o_press_mask | o_slow_repeat_mask | o_fast_repeat_mask) & ~o_level_mask) == '0)
    // every press edge appears in both repeat masks
    `GEA_ASSERT_IMPL(a_press_in_repeat, i_clk, i_rst_n, o_out_valid, (o_press_mask & ~(o_slow_repeat_mask & o_fast_repeat_mask)) == '0)
    // an accepted beat always leaves a result waiting
    `GEA_ASSERT_NEXT(a_beat_gives_result, i_clk, i_rst_n, in_beat, o_out_valid)

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// gamepad edge and auto-repeat testbench
// drives controller samples through the valid/ready input, predicts the five
// line masks of every sample with a cycle-free model of levels, edges and
// per-line hold counters, and checks each output beat in order. registers
// are rewritten between phases, with the block drained, over several timing
// and threshold settings including zero delay, saturation and large reloads
// ----------------------------------------------------------------------------
module tb_top;
    import gea_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_SAMPLES  = 160;

    // five masks of one result beat
    typedef struct packed {
        logic [LINE_COUNT-1:0] level;
        logic [LINE_COUNT-1:0] press;
        logic [LINE_COUNT-1:0] rel;
        logic [LINE_COUNT-1:0] slow;
        logic [LINE_COUNT-1:0] fast;
    } t_line_masks;

    // one controller sample
    typedef struct packed {
        logic [BTN_COUNT-1:0] btn;
        logic [AXIS_W-1:0]    lx;
        logic [AXIS_W-1:0]    ly;
        logic [AXIS_W-1:0]    rx;
        logic [AXIS_W-1:0]    ry;
    } t_pad_sample;

    // ------------------------------------------------------------------------
    // scoreboard: line predictor plus queue of expected masks
    // ------------------------------------------------------------------------
    class pad_scoreboard;
        bit                   enter_circle;
        bit [THR_W-1:0]       threshold;
        bit [CNT_W-1:0]       delay;
        bit [CNT_W-1:0]       reload;
        bit [SRC_LINES-1:0]   last_levels;
        bit [CNT_W-1:0]       slow_cnt [SRC_LINES];
        bit [CNT_W-1:0]       fast_cnt [SRC_LINES];
        t_line_masks          expected_q [$];
        int                   errors;
        int                   beats;

        function new();
            enter_circle = 1'b0;
            threshold    = THR_RST;
            delay        = DELAY_RST;
            reload       = RELOAD_RST;
            last_levels  = '0;
            foreach (slow_cnt[i]) begin
                slow_cnt[i] = '0;
                fast_cnt[i] = '0;
            end
            errors = 0;
            beats  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // register write, only the low bits of each register count
        function void set_cfg(t_cfg_idx idx, bit [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_ENTER_IS_CIRCLE: enter_circle = d[0];
                CFG_AXIS_THRESHOLD:  threshold    = d[THR_W-1:0];
                CFG_REPEAT_DELAY:    delay        = d[CNT_W-1:0];
                CFG_REPEAT_RELOAD:   reload       = d[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // low side pressed below centre minus threshold, high side above plus
        function bit [1:0] stick_dirs(bit [AXIS_W-1:0] a);
            int lo;
            int hi;
            lo = int'(AXIS_CENTRE) - int'(threshold);
            hi = int'(AXIS_CENTRE) + int'(threshold);
            if (int'(a) < lo) return 2'b01;
            if (int'(a) > hi) return 2'b10;
            return 2'b00;
        endfunction

        // source lines to output layout, enter and cancel inserted at 12/13
        function bit [LINE_COUNT-1:0] to_lines(bit [SRC_LINES-1:0] src);
            bit enter;
            bit cancel;
            enter  = enter_circle ? src[BTN_CIRCLE] : src[BTN_CROSS];
            cancel = enter_circle ? src[BTN_CROSS] : src[BTN_CIRCLE];
            return {src[SRC_LINES-1:BTN_COUNT], cancel, enter, src[BTN_COUNT-1:0]};
        endfunction

        // accepted sample: advance levels and hold counters, queue the masks
        function void note_sample(t_pad_sample s);
            bit [SRC_LINES-1:0] cur;
            bit [SRC_LINES-1:0] press;
            bit [SRC_LINES-1:0] rel;
            bit [SRC_LINES-1:0] slow;
            bit [SRC_LINES-1:0] fast;
            bit [CNT_W-1:0]     sc;
            bit [CNT_W-1:0]     fc;
            t_line_masks        m;
            cur   = {stick_dirs(s.rx), stick_dirs(s.ry), stick_dirs(s.lx),
                     stick_dirs(s.ly), s.btn};
            press = cur & ~last_levels;
            rel   = ~cur & last_levels;
            slow  = '0;
            fast  = '0;
            for (int i = 0; i < SRC_LINES; i++) begin
                if (cur[i]) begin
                    sc = slow_cnt[i];
                    fc = fast_cnt[i];
                    if (sc >= delay) begin
                        slow[i] = 1'b1;
                        sc      = reload;
                    end
                    if (fc >= delay) begin
                        fast[i] = 1'b1;
                        fc      = delay;
                    end
                    // counters saturate rather than wrap
                    slow_cnt[i] = (sc < CNT_MAX) ? sc + 1'b1 : CNT_MAX;
                    fast_cnt[i] = (fc < CNT_MAX) ? fc + 1'b1 : CNT_MAX;
                end else begin
                    slow_cnt[i] = '0;
                    fast_cnt[i] = '0;
                end
            end
            last_levels = cur;
            m.level = to_lines(cur);
            m.press = to_lines(press);
            m.rel   = to_lines(rel);
            m.slow  = to_lines(slow | press);
            m.fast  = to_lines(fast | press);
            expected_q.push_back(m);
        endfunction

        task report_mismatch(string what, bit [LINE_COUNT-1:0] got,
                             bit [LINE_COUNT-1:0] want);
            $display("beat %0d %s: got %06h, expected %06h", beats, what, got, want);
            errors++;
        endtask

        task compare_field(string what, bit [LINE_COUNT-1:0] got,
                           bit [LINE_COUNT-1:0] want);
            if (got !== want) report_mismatch(what, got, want);
        endtask

        // accepted output beat against the oldest expectation
        task check_result(t_line_masks got);
            t_line_masks want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected beat, level", got.level, '0);
            end else begin
                want = expected_q.pop_front();
                compare_field("level", got.level, want.level);
                compare_field("press", got.press, want.press);
                compare_field("release", got.rel, want.rel);
                compare_field("slow repeat", got.slow, want.slow);
                compare_field("fast repeat", got.fast, want.fast);
            end
            beats++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_ready;
    logic [BTN_COUNT-1:0]  i_button_bits = '0;
    logic [AXIS_W-1:0]     i_left_x      = AXIS_CENTRE;
    logic [AXIS_W-1:0]     i_left_y      = AXIS_CENTRE;
    logic [AXIS_W-1:0]     i_right_x     = AXIS_CENTRE;
    logic [AXIS_W-1:0]     i_right_y     = AXIS_CENTRE;
    logic                  o_out_valid;
    logic                  i_out_ready   = 1'b0;
    logic [LINE_COUNT-1:0] o_level_mask;
    logic [LINE_COUNT-1:0] o_press_mask;
    logic [LINE_COUNT-1:0] o_release_mask;
    logic [LINE_COUNT-1:0] o_slow_repeat_mask;
    logic [LINE_COUNT-1:0] o_fast_repeat_mask;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    pad_scoreboard sb = new();
    bit            calm = 1'b0;
    int            quiet_cycles = 0;

    // sticky controller state for well-formed hold sequences
    logic [BTN_COUNT-1:0]  held_btn = '0;
    logic [AXIS_W-1:0]     held_axis [4];

    gamepad_edge_and_autorepeat uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_button_bits      (i_button_bits),
        .i_left_x           (i_left_x),
        .i_left_y           (i_left_y),
        .i_right_x          (i_right_x),
        .i_right_y          (i_right_y),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_level_mask       (o_level_mask),
        .o_press_mask       (o_press_mask),
        .o_release_mask     (o_release_mask),
        .o_slow_repeat_mask (o_slow_repeat_mask),
        .o_fast_repeat_mask (o_fast_repeat_mask),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 6);
    end

    // beat monitor: outputs first, then the accepted sample
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_result({o_level_mask, o_press_mask, o_release_mask,
                                 o_slow_repeat_mask, o_fast_repeat_mask});
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_sample({i_button_bits, i_left_x, i_left_y, i_right_x, i_right_y});
            end
        end
    end

    // watchdog on cycles with no beat and no register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_pad_sample mk(int btn, int lx, int ly, int rx, int ry);
        t_pad_sample s;
        s.btn = btn[BTN_COUNT-1:0];
        s.lx  = lx[AXIS_W-1:0];
        s.ly  = ly[AXIS_W-1:0];
        s.rx  = rx[AXIS_W-1:0];
        s.ry  = ry[AXIS_W-1:0];
        return s;
    endfunction

    // axis value biased towards the extremes and the threshold edges
    function automatic logic [AXIS_W-1:0] pick_axis();
        int c;
        int t;
        t = int'(sb.threshold);
        case ($urandom_range(7))
            0:       c = 0;
            1:       c = 255;
            2:       c = 128;
            3:       c = 128 - t - 1;
            4:       c = 128 - t;
            5:       c = 128 + t;
            6:       c = (128 + t + 1 > 255) ? 255 : 128 + t + 1;
            default: c = $urandom_range(255);
        endcase
        return c[AXIS_W-1:0];
    endfunction

    // mostly held buttons and sticks with rare changes, some pure noise
    function automatic t_pad_sample next_sample();
        t_pad_sample s;
        logic [63:0] raw;
        if ($urandom_range(99) < 15) begin
            raw = {$urandom, $urandom};
            s   = raw[$bits(t_pad_sample)-1:0];
        end else begin
            for (int b = 0; b < BTN_COUNT; b++) begin
                if ($urandom_range(99) < 5) held_btn[b] = ~held_btn[b];
            end
            for (int a = 0; a < 4; a++) begin
                if ($urandom_range(99) < 8) held_axis[a] = pick_axis();
            end
            s = {held_btn, held_axis[0], held_axis[1], held_axis[2], held_axis[3]};
        end
        return s;
    endfunction

    // present one sample and hold it until taken, then maybe idle a while
    task automatic send_sample(t_pad_sample s);
        i_in_valid    <= 1'b1;
        i_button_bits <= s.btn;
        i_left_x      <= s.lx;
        i_left_y      <= s.ly;
        i_right_x     <= s.rx;
        i_right_y     <= s.ry;
        do @(posedge i_clk); while (!o_in_ready);
        while (!calm && $urandom_range(99) < 6) begin
            i_in_valid    <= 1'b0;
            i_button_bits <= BTN_COUNT'($urandom);
            i_left_x      <= AXIS_W'($urandom);
            i_right_y     <= AXIS_W'($urandom);
            @(posedge i_clk);
        end
    endtask

    // hold off until every queued result has been taken
    task automatic wait_drain();
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        sb.set_cfg(idx, d);
    endtask

    // all four registers, spare upper bits of the write data scrambled
    task automatic apply_setting(int enter, int thr, int dly, int rld);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        d[0] = enter[0];
        write_reg(CFG_ENTER_IS_CIRCLE, d);
        write_reg(CFG_AXIS_THRESHOLD, thr[CFG_DATA_W-1:0]);
        d = CFG_DATA_W'($urandom);
        d[CNT_W-1:0] = dly[CNT_W-1:0];
        write_reg(CFG_REPEAT_DELAY, d);
        d = CFG_DATA_W'($urandom);
        d[CNT_W-1:0] = rld[CNT_W-1:0];
        write_reg(CFG_REPEAT_RELOAD, d);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        foreach (held_axis[a]) held_axis[a] = AXIS_CENTRE;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, long hold through the reset delay, threshold edges,
        // circle and cross alone and together
        send_sample(mk(0, 128, 128, 128, 128));
        repeat (13) send_sample(mk(12'hFFF, 0, 0, 0, 0));
        send_sample(mk(0, 255, 255, 255, 255));
        send_sample(mk(12'h180, 63, 64, 192, 193));
        send_sample(mk(12'h080, 64, 63, 193, 192));
        send_sample(mk(12'h100, 128, 128, 128, 128));
        send_sample(mk(0, 128, 128, 128, 128));
        i_in_valid <= 1'b0;
        wait_drain();

        // phases over register settings, fixed corners then random ones
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0:       apply_setting(1, 0, 1, 0);
                1:       apply_setting(0, 127, 15, 14);
                2:       apply_setting(1, 64, 0, 0);
                3:       apply_setting(0, 32, 3, 15);
                4:       apply_setting(1, 100, 15, 15);
                5:       apply_setting(0, 1, 5, 5);
                default: apply_setting($urandom_range(1), $urandom_range(127),
                                       $urandom_range(15), $urandom_range(15));
            endcase
            calm = (p == 4);
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                // sender holds off mid phase until the output side has caught up
                if (p == 2 && n == PHASE_SAMPLES / 2) begin
                    i_in_valid <= 1'b0;
                    wait_drain();
                end
                send_sample(next_sample());
            end
            i_in_valid <= 1'b0;
            wait_drain();
        end
        calm = 1'b0;

        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- gamepad_edge_and_autorepeat.f -----
+incdir+rtl
rtl/gea_pkg.sv
rtl/gea_repeat.sv
rtl/gamepad_edge_and_autorepeat.sv
dv/tb_top.sv
